@@ rtl/r2fft_pkg.sv @@
package r2fft_pkg;

  typedef struct packed {
    logic signed [15:0] sample_re;
    logic signed [15:0] sample_im;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] bin_re;
    logic signed [23:0] bin_im;
    logic [5:0]         bin_index;
    logic               last_bin;
  } out_item_t;

  localparam int DW = 24;
  localparam int TWW = 17;
  localparam logic signed [23:0] SAT_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] SAT_MIN = -24'sh800000;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RD,
    ST_MUL,
    ST_WR,
    ST_OUT,
    ST_OUTW
  } eng_state_t;

  // Saturate a wide signed value to 24 bits.
  function automatic logic signed [23:0] sat24(input logic signed [27:0] x);
    logic signed [23:0] r;
    if (x > 28'sd8388607) r = SAT_MAX;
    else if (x < -28'sd8388608) r = SAT_MIN;
    else r = x[23:0];
    return r;
  endfunction

  // Twiddle for angle 2*pi*t/n in Q15, computed once at elaboration.
  function automatic logic signed [TWW-1:0] tw_val(input int t, input int lg,
                                                   input bit want_sin);
    longint rc [32];
    longint rs [32];
    longint v, r, bitv, c, s, cr, ci, nr, ni, q;
    longint num, rem;
    int m, b, k, i;
    for (m = 0; m < 32; m++) begin
      rc[m] = 0;
      rs[m] = 0;
    end
    rs[1] = 64'sd1 << 30;
    for (m = 2; m < lg && m < 32; m++) begin
      v = ((64'sd1 << 30) + rc[m-1]) << 29;
      r = 0;
      bitv = 64'sd1 << 62;
      while (bitv > v) bitv = bitv >>> 2;
      while (bitv != 0) begin
        if (v >= r + bitv) begin
          v = v - (r + bitv);
          r = (r >>> 1) + bitv;
        end else begin
          r = r >>> 1;
        end
        bitv = bitv >>> 2;
      end
      c = (r == 0) ? 64'sd1 : r;
      // rounded quotient by restoring division
      num = (rs[m-1] << 29) + (c >>> 1);
      rem = 0;
      s = 0;
      for (i = 62; i >= 0; i--) begin
        rem = (rem << 1) | ((num >>> i) & 64'sd1);
        if (rem >= c) begin
          rem = rem - c;
          s = s | (64'sd1 << i);
        end
      end
      rc[m] = c;
      rs[m] = s;
    end
    cr = 64'sd1 << 30;
    ci = 0;
    for (b = 0; b + 1 < lg; b++) begin
      if (((t >> b) & 1) != 0) begin
        k = lg - 1 - b;
        nr = (cr * rc[k] - ci * rs[k] + (64'sd1 << 29)) >>> 30;
        ni = (cr * rs[k] + ci * rc[k] + (64'sd1 << 29)) >>> 30;
        cr = nr;
        ci = ni;
      end
    end
    q = want_sin ? ci : cr;
    q = (q + (64'sd1 << 14)) >>> 15;
    return q[TWW-1:0];
  endfunction

endpackage

@@ rtl/r2fft_front.sv @@
module r2fft_front #(
  parameter int POINTS = 64,
  parameter int AW = $clog2(POINTS)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  r2fft_pkg::in_item_t  in_data,
  input  logic                 q_ready,
  output logic                 q_valid,
  output r2fft_pkg::in_item_t  q_data,
  output logic [AW-1:0]        q_addr,
  output logic                 q_last
);

  // Two-entry queue of samples tagged with their bit-reversed address.
  logic [AW:0] cnt_r, cnt_nxt;
  r2fft_pkg::in_item_t d_r [2];
  logic [AW-1:0] a_r [2];
  logic l_r [2];
  logic [1:0] fill_r;
  logic wp_r, rp_r;
  logic push, pop;
  logic [AW-1:0] rev;

  always_comb begin
    for (int i = 0; i < AW; i++) rev[i] = cnt_r[AW-1-i];
  end

  assign in_ready = (fill_r != 2'd2);
  assign push = in_valid && in_ready;
  assign q_valid = (fill_r != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_data = d_r[rp_r];
  assign q_addr = a_r[rp_r];
  assign q_last = l_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push) cnt_nxt = (cnt_r == (AW+1)'(POINTS - 1)) ? '0 : cnt_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      fill_r <= '0;
      wp_r <= 1'b0;
      rp_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      fill_r <= fill_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      d_r[wp_r] <= in_data;
      a_r[wp_r] <= rev;
      l_r[wp_r] <= (cnt_r == (AW+1)'(POINTS - 1));
    end
  end

endmodule

@@ rtl/r2fft_back.sv @@
module r2fft_back #(
  parameter int POINTS = 64,
  parameter int AW = $clog2(POINTS)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 inv_mode,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  r2fft_pkg::in_item_t  q_data,
  input  logic [AW-1:0]        q_addr,
  input  logic                 q_last,
  output logic                 out_valid,
  input  logic                 out_ready,
  output r2fft_pkg::out_item_t out_data
);

  localparam int TN = (POINTS / 2 > 1) ? POINTS / 2 : 1;
  localparam int TA = (TN > 1) ? $clog2(TN) : 1;
  localparam int SW = (AW > 1) ? $clog2(AW) : 1;

  logic signed [r2fft_pkg::TWW-1:0] cos_tab [TN];
  logic signed [r2fft_pkg::TWW-1:0] sin_tab [TN];
  for (genvar g = 0; g < TN; g++) begin : g_tw
    assign cos_tab[g] = r2fft_pkg::tw_val(g, AW, 1'b0);
    assign sin_tab[g] = r2fft_pkg::tw_val(g, AW, 1'b1);
  end

  // Two memories, each written by one port, let a and b be read in the same cycle.
  logic [47:0] mem_a [POINTS];
  logic [47:0] mem_b [POINTS];
  logic [47:0] rda_r, rdb_r;

  r2fft_pkg::eng_state_t st_r, st_nxt;
  logic [SW-1:0] stg_r;
  logic [AW-1:0] bf_r;
  logic [AW-1:0] oidx_r;
  logic inv_r;
  logic [AW-1:0] addr_a, addr_b;
  logic [TA-1:0] tidx;

  // butterfly j within group: low stg bits of bf; group i from the rest
  logic [AW-1:0] half, jmask;
  always_comb begin
    half = AW'(1) << stg_r;
    jmask = half - 1'b1;
    addr_a = ((bf_r & ~jmask) << 1) | (bf_r & jmask);
    addr_b = addr_a | half;
    tidx = TA'(((bf_r & jmask) << (AW - 1 - 32'(stg_r))));
  end

  logic signed [r2fft_pkg::TWW-1:0] wr_r, wi_r;
  logic signed [41:0] p1_r, p2_r, p3_r, p4_r;
  logic [AW-1:0] aa_r, ab_r;

  logic mem_we;
  logic [AW-1:0] wa_addr, wb_addr;
  logic [47:0] wa_data, wb_data;
  logic wb_en;

  logic signed [23:0] ur, ui, br, bi;

  logic signed [42:0] vr_w, vi_w;
  logic signed [27:0] vr, vi;
  always_comb begin
    vr_w = ({p1_r[41], p1_r} - {p2_r[41], p2_r} + 43'sd16384) >>> 15;
    vi_w = ({p3_r[41], p3_r} + {p4_r[41], p4_r} + 43'sd16384) >>> 15;
    vr = vr_w[27:0];
    vi = vi_w[27:0];
  end

  logic signed [23:0] ua_r, ui_r;
  always_ff @(posedge clk) begin
    if (st_r == r2fft_pkg::ST_RD) begin
      wr_r <= cos_tab[tidx];
      wi_r <= inv_r ? sin_tab[tidx] : -sin_tab[tidx];
      aa_r <= addr_a;
      ab_r <= addr_b;
    end
    if (st_r == r2fft_pkg::ST_MUL) begin
      p1_r <= 42'(br * wr_r);
      p2_r <= 42'(bi * wi_r);
      p3_r <= 42'(br * wi_r);
      p4_r <= 42'(bi * wr_r);
      ua_r <= ur;
      ui_r <= ui;
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      r2fft_pkg::ST_LOAD: if (q_valid && q_last) st_nxt = r2fft_pkg::ST_RD;
      r2fft_pkg::ST_RD:   st_nxt = r2fft_pkg::ST_MUL;
      r2fft_pkg::ST_MUL:  st_nxt = r2fft_pkg::ST_WR;
      r2fft_pkg::ST_WR:
        if (bf_r == AW'(POINTS / 2 - 1) && stg_r == SW'(AW - 1)) st_nxt = r2fft_pkg::ST_OUTW;
        else st_nxt = r2fft_pkg::ST_RD;
      r2fft_pkg::ST_OUTW: st_nxt = r2fft_pkg::ST_OUT;
      r2fft_pkg::ST_OUT:
        if (out_ready && oidx_r == AW'(POINTS - 1)) st_nxt = r2fft_pkg::ST_LOAD;
        else if (out_ready) st_nxt = r2fft_pkg::ST_OUTW;
      default: st_nxt = r2fft_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    q_ready = (st_r == r2fft_pkg::ST_LOAD);
    out_valid = (st_r == r2fft_pkg::ST_OUT);
    mem_we = 1'b0;
    wb_en = 1'b0;
    wa_addr = q_addr;
    wb_addr = ab_r;
    wa_data = {{8{q_data.sample_re[15]}}, q_data.sample_re,
               {8{q_data.sample_im[15]}}, q_data.sample_im};
    wb_data = '0;
    unique case (st_r)
      r2fft_pkg::ST_LOAD: mem_we = q_valid;
      r2fft_pkg::ST_WR: begin
        mem_we = 1'b1;
        wb_en = 1'b1;
        wa_addr = aa_r;
        wa_data = {r2fft_pkg::sat24(28'(ua_r) + vr), r2fft_pkg::sat24(28'(ui_r) + vi)};
        wb_data = {r2fft_pkg::sat24(28'(ua_r) - vr), r2fft_pkg::sat24(28'(ui_r) - vi)};
      end
      default: ;
    endcase
  end

  // mem_a takes the port a write and mem_b the port b write
  always_ff @(posedge clk) begin
    if (mem_we) mem_a[wa_addr] <= wa_data;
    if (wb_en) mem_b[wb_addr] <= wb_data;
    if (st_r == r2fft_pkg::ST_RD) begin
      rda_r <= mem_a[addr_a];
      rdb_r <= mem_b[addr_b];
    end else if (st_r == r2fft_pkg::ST_OUTW) begin
      rda_r <= mem_a[oidx_r];
    end
  end

  // second copies keep both sides complete: a-side value into mem_b2, b-side into mem_a2
  logic [47:0] mem_a2 [POINTS];
  logic [47:0] mem_b2 [POINTS];
  logic [47:0] rda2_r, rdb2_r;
  always_ff @(posedge clk) begin
    if (wb_en) mem_a2[wb_addr] <= wb_data;
    if (mem_we) mem_b2[wa_addr] <= wa_data;
    if (st_r == r2fft_pkg::ST_RD) begin
      rda2_r <= mem_a2[addr_a];
      rdb2_r <= mem_b2[addr_b];
    end else if (st_r == r2fft_pkg::ST_OUTW) begin
      rda2_r <= mem_a2[oidx_r];
    end
  end

  // per-entry tag: which port (a or b) wrote the newest value, selecting the copy that holds it
  logic [POINTS-1:0] tag_r;
  always_ff @(posedge clk) begin
    if (mem_we) tag_r[wa_addr] <= 1'b0;
    if (wb_en) tag_r[wb_addr] <= 1'b1;
  end
  logic ta_r, tb_r;
  always_ff @(posedge clk) begin
    if (st_r == r2fft_pkg::ST_RD) begin
      ta_r <= tag_r[addr_a];
      tb_r <= tag_r[addr_b];
    end else if (st_r == r2fft_pkg::ST_OUTW) begin
      ta_r <= tag_r[oidx_r];
    end
  end
  logic [47:0] va, vb;
  assign va = ta_r ? rda2_r : rda_r;
  assign vb = tb_r ? rdb_r : rdb2_r;

  assign ur = va[47:24];
  assign ui = va[23:0];
  assign br = vb[47:24];
  assign bi = vb[23:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= r2fft_pkg::ST_LOAD;
      stg_r <= '0;
      bf_r <= '0;
      oidx_r <= '0;
      inv_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == r2fft_pkg::ST_LOAD && q_valid && q_last) begin
        inv_r <= inv_mode;
        stg_r <= '0;
        bf_r <= '0;
        oidx_r <= '0;
      end
      if (st_r == r2fft_pkg::ST_WR) begin
        if (bf_r == AW'(POINTS / 2 - 1)) begin
          bf_r <= '0;
          stg_r <= stg_r + 1'b1;
        end else begin
          bf_r <= bf_r + 1'b1;
        end
      end
      if (st_r == r2fft_pkg::ST_OUT && out_ready) oidx_r <= oidx_r + 1'b1;
    end
  end

  logic signed [23:0] xr, xi;
  logic signed [24:0] rr, ri;
  always_comb begin
    xr = va[47:24];
    xi = va[23:0];
    rr = (25'(xr) + (25'sd1 <<< (AW - 1))) >>> AW;
    ri = (25'(xi) + (25'sd1 <<< (AW - 1))) >>> AW;
    out_data.bin_re = inv_r ? rr[23:0] : xr;
    out_data.bin_im = inv_r ? ri[23:0] : xi;
    out_data.bin_index = 6'(oidx_r);
    out_data.last_bin = (oidx_r == AW'(POINTS - 1));
  end

endmodule

@@ rtl/radix2_fft_engine.sv @@
// After the last sample, one shared butterfly unit runs each butterfly in
// turn through RD, MUL and WR, stage by stage; each bin is then read from
// memory (OUTW) before its transfer (OUT). Throughput: one sample per cycle
// while loading; a new frame loads only after the last bin is out.
// Reset (rst_n, synchronous): load count, queue and engine state clear; the
// sample memory keeps its contents and is written before it is read.
module radix2_fft_engine #(
  parameter int POINTS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  r2fft_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output r2fft_pkg::out_item_t out_data
);

  localparam int AW = $clog2(POINTS);

  logic inv_r;
  always_ff @(posedge clk) begin
    if (!rst_n) inv_r <= 1'b0;
    else if (cfg_we) inv_r <= cfg_wdata;
  end

  logic q_valid, q_ready, q_last;
  r2fft_pkg::in_item_t q_data;
  logic [AW-1:0] q_addr;

  r2fft_front #(.POINTS(POINTS), .AW(AW)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .q_ready, .q_valid, .q_data, .q_addr, .q_last
  );

  r2fft_back #(.POINTS(POINTS), .AW(AW)) u_back (
    .clk, .rst_n, .inv_mode(inv_r), .q_valid, .q_ready, .q_data, .q_addr, .q_last,
    .out_valid, .out_ready, .out_data
  );

endmodule

@@ tb/radix2_fft_engine_tb.sv @@
`timescale 1ns / 1ps

module radix2_fft_engine_tb;

  localparam int NPTS = 64;
  localparam int LGN = 6;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int BP_EXTRA = 8;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;
  logic in_valid;
  logic in_ready;
  r2fft_pkg::in_item_t in_data;
  logic out_valid;
  logic out_ready;
  r2fft_pkg::out_item_t out_data;

  radix2_fft_engine #(.POINTS(NPTS)) uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
  end
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic signed [23:0] frame_re [NPTS];
  logic signed [23:0] frame_im [NPTS];
  int load_cnt;
  bit inv_mode;
  longint cos_tab [NPTS/2];
  longint sin_tab [NPTS/2];

  r2fft_pkg::out_item_t bin_queue [$];
  int err_count;
  int idle_cycles;
  bit rx_hold;
  int rx_wait;
  int rx_draw;

  function automatic longint rshift_round(longint x, int n);
    if (n == 0) return x;
    return (x + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic logic signed [23:0] clip24(longint x);
    if (x > 8388607) return 24'sh7FFFFF;
    if (x < -8388608) return -24'sh800000;
    return x[23:0];
  endfunction

  task automatic make_twiddles();
    longint rc [32];
    longint rs [32];
    longint v, r, bitv, c, cr, ci, nr, ni;
    int m, t, b, k;
    for (m = 0; m < 32; m++) begin
      rc[m] = 0;
      rs[m] = 0;
    end
    rs[1] = 64'sd1 <<< 30;
    for (m = 2; m < LGN; m++) begin
      v = ((64'sd1 <<< 30) + rc[m-1]) <<< 29;
      r = 0;
      bitv = 64'sd1 <<< 62;
      while (bitv > v) bitv = bitv >>> 2;
      while (bitv != 0) begin
        if (v >= r + bitv) begin
          v = v - (r + bitv);
          r = (r >>> 1) + bitv;
        end else begin
          r = r >>> 1;
        end
        bitv = bitv >>> 2;
      end
      c = (r == 0) ? 1 : r;
      rc[m] = c;
      rs[m] = ((rs[m-1] <<< 29) + c / 2) / c;
    end
    for (t = 0; t < NPTS / 2; t++) begin
      cr = 64'sd1 <<< 30;
      ci = 0;
      for (b = 0; b + 1 < LGN; b++) begin
        if (((t >> b) & 1) != 0) begin
          k = LGN - 1 - b;
          nr = rshift_round(cr * rc[k] - ci * rs[k], 30);
          ni = rshift_round(cr * rs[k] + ci * rc[k], 30);
          cr = nr;
          ci = ni;
        end
      end
      cos_tab[t] = rshift_round(cr, 15);
      sin_tab[t] = rshift_round(ci, 15);
    end
  endtask

  task automatic compute_spectrum();
    logic signed [23:0] xr [NPTS];
    logic signed [23:0] xi [NPTS];
    longint wr, wi, br, bi, ur, ui, vr, vi;
    int i, j, r, a, bb, half, stride, t;
    r2fft_pkg::out_item_t o;
    for (i = 0; i < NPTS; i++) begin
      r = 0;
      for (j = 0; j < LGN; j++) r |= ((i >> j) & 1) << (LGN - 1 - j);
      xr[r] = frame_re[i];
      xi[r] = frame_im[i];
    end
    for (half = 1; half < NPTS; half <<= 1) begin
      stride = NPTS / (2 * half);
      for (i = 0; i < NPTS; i += 2 * half) begin
        for (j = 0; j < half; j++) begin
          a = i + j;
          bb = a + half;
          t = (j * stride) % (NPTS / 2);
          wr = cos_tab[t];
          wi = inv_mode ? sin_tab[t] : -sin_tab[t];
          br = xr[bb];
          bi = xi[bb];
          ur = xr[a];
          ui = xi[a];
          vr = rshift_round(br * wr - bi * wi, 15);
          vi = rshift_round(br * wi + bi * wr, 15);
          xr[a] = clip24(ur + vr);
          xi[a] = clip24(ui + vi);
          xr[bb] = clip24(ur - vr);
          xi[bb] = clip24(ui - vi);
        end
      end
    end
    for (i = 0; i < NPTS; i++) begin
      if (inv_mode) begin
        xr[i] = clip24(rshift_round(xr[i], LGN));
        xi[i] = clip24(rshift_round(xi[i], LGN));
      end
      o.bin_re = xr[i];
      o.bin_im = xi[i];
      o.bin_index = i[5:0];
      o.last_bin = (i == NPTS - 1);
      bin_queue.push_back(o);
    end
  endtask

  task automatic add_sample(r2fft_pkg::in_item_t s);
    frame_re[load_cnt] = 24'(s.sample_re);
    frame_im[load_cnt] = 24'(s.sample_im);
    load_cnt++;
    if (load_cnt == NPTS) begin
      compute_spectrum();
      load_cnt = 0;
    end
  endtask

  // valid stays up across back-to-back items; it drops only for a gap
  task automatic send_sample(r2fft_pkg::in_item_t s, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    add_sample(s);
  endtask

  function automatic r2fft_pkg::in_item_t rand_sample();
    r2fft_pkg::in_item_t s;
    case ($urandom_range(0, 4))
      0: s.sample_re = 16'sh7FFF;
      1: s.sample_re = -16'sh8000;
      default: s.sample_re = 16'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0: s.sample_im = 16'sh7FFF;
      1: s.sample_im = -16'sh8000;
      default: s.sample_im = 16'($urandom);
    endcase
    return s;
  endfunction

  task automatic drain_results();
    in_valid <= 1'b0;
    while (bin_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_direction(bit inverse);
    in_valid <= 1'b0;
    cfg_we <= 1'b1;
    cfg_wdata <= inverse;
    @(posedge clk);
    cfg_we <= 1'b0;
    inv_mode = inverse;
  endtask

  // receiver: draws a wait per bin, or is held off entirely while rx_hold is set
  always @(posedge clk) begin
    if (!rst_n || rx_hold) begin
      out_ready <= 1'b0;
      rx_wait <= 0;
    end else if (out_valid && out_ready) begin
      rx_draw = $urandom_range(0, 18);
      rx_wait <= rx_draw;
      out_ready <= (rx_draw == 0);
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      out_ready <= (rx_wait == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    r2fft_pkg::out_item_t exp_bin;
    if (rst_n && out_valid && out_ready) begin
      if (bin_queue.size() == 0) begin
        $error("unexpected bin transfer index=%0d", out_data.bin_index);
        err_count++;
      end else begin
        exp_bin = bin_queue.pop_front();
        if (out_data.bin_re !== exp_bin.bin_re) begin
          $error("bin_re exp=%0d got=%0d", exp_bin.bin_re, out_data.bin_re);
          err_count++;
        end
        if (out_data.bin_im !== exp_bin.bin_im) begin
          $error("bin_im exp=%0d got=%0d", exp_bin.bin_im, out_data.bin_im);
          err_count++;
        end
        if (out_data.bin_index !== exp_bin.bin_index) begin
          $error("bin_index exp=%0d got=%0d", exp_bin.bin_index, out_data.bin_index);
          err_count++;
        end
        if (out_data.last_bin !== exp_bin.last_bin) begin
          $error("last_bin exp=%0d got=%0d", exp_bin.last_bin, out_data.last_bin);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // directed frame: extremes, zeros, alternating bit patterns, random fill
  task automatic test_directed_frame();
    r2fft_pkg::in_item_t s;
    int i;
    for (i = 0; i < NPTS; i++) begin
      case (i % 8)
        0: begin s.sample_re = 16'sh7FFF; s.sample_im = 16'sh7FFF; end
        1: begin s.sample_re = -16'sh8000; s.sample_im = -16'sh8000; end
        2: begin s.sample_re = 16'sh7FFF; s.sample_im = -16'sh8000; end
        3: begin s.sample_re = '0; s.sample_im = '0; end
        4: begin s.sample_re = 16'sh5555; s.sample_im = 16'shAAAA; end
        default: s = rand_sample();
      endcase
      send_sample(s);
    end
    drain_results();
  endtask

  // direction written mid-load: the setting at the last sample applies
  task automatic test_mode_change_mid_load();
    int i;
    for (i = 0; i < NPTS; i++) begin
      if (i == NPTS / 2) set_direction(!inv_mode);
      send_sample(rand_sample());
    end
    drain_results();
  endtask

  // receiver holds off while the sender keeps pushing into the next frame
  task automatic test_backpressure();
    int i;
    rx_hold = 1'b1;
    for (i = 0; i < NPTS; i++) send_sample(rand_sample(), 1);
    fork
      begin
        for (i = 0; i < BP_EXTRA; i++) send_sample(rand_sample(), 1);
      end
      begin
        repeat (2000) @(posedge clk);
        rx_hold = 1'b0;
      end
    join
    drain_results();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    rx_hold = 1'b0;
    err_count = 0;
    load_cnt = 0;
    inv_mode = 1'b0;
    make_twiddles();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_direction(1'b0);
    test_directed_frame();
    test_mode_change_mid_load();
    test_backpressure();
    drain_results();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
